FILE: design/ucd_pkg.sv
// constants for the seconds-to-civil-datetime pipeline
// no dependencies; imported by the top level
package ucd_pkg;

  localparam int unsigned EraShift      = 3670;
  localparam int unsigned EraDays       = 146097;
  localparam int unsigned EraYears      = 400;
  localparam int unsigned EpochDays     = 719468;
  localparam int unsigned DaySecs       = 86400;
  localparam int unsigned DaysW         = 30;
  localparam int unsigned SecsShift     = 7;
  localparam int unsigned DayRest       = DaySecs >> SecsShift;
  localparam int unsigned MinSecs       = 60;
  localparam int unsigned YearStep      = 2939745;
  localparam int unsigned YearStepQuad  = 4 * YearStep;
  localparam int unsigned MonthMul      = 2141;
  localparam int unsigned MonthAdd      = 197913;
  localparam int unsigned MarchYearDays = 306;
  localparam int unsigned CenturyYears  = 100;
  localparam int unsigned MonthsPerYear = 12;

  localparam logic [48:0] ShiftSecs =
    49'((64'(EraShift) * 64'(EraDays) + 64'(EpochDays)) * 64'(DaySecs));
  localparam logic [47:0] MaxShifted =
    48'((64'd1 << DaysW) * 64'(DaySecs) - 64'd1);
  localparam logic [21:0] ShiftYears = 22'(EraShift * EraYears);

endpackage

FILE: design/ucd_const_div.sv
// two-stage divider by a constant: reciprocal estimate, then one correction
// self-contained; carries a valid bit and a sideband vector along
module ucd_const_div #(
  parameter int unsigned Divisor = 675,
  parameter int unsigned XW      = 20,
  parameter int unsigned QW      = 11,
  parameter int unsigned SW      = 1,
  localparam int unsigned DW     = $clog2(Divisor + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o,
  output logic [DW-1:0] r_o,
  output logic [SW-1:0] side_o
);

  localparam logic [63:0] RecipFull = (64'd1 << XW) / 64'(Divisor);
  localparam int unsigned MW = $clog2(RecipFull + 64'd1);
  localparam logic [MW-1:0] Recip = MW'(RecipFull);
  localparam logic [DW-1:0] DivW = DW'(Divisor);

  logic [XW+MW-1:0] est_prod;
  logic [QW+DW-1:0] chk_prod;
  logic [XW-1:0]    rem_full;
  logic             fix;

  logic          v1_q, v2_q;
  logic [XW-1:0] x1_q;
  logic [QW-1:0] q1_q, q2_q;
  logic [SW-1:0] s1_q, s2_q;
  logic [DW-1:0] r2_q;
  logic [QW-1:0] q1_d, q2_d;
  logic [DW-1:0] r2_d;

  // estimate is the true quotient or one below
  assign est_prod = (XW+MW)'(x_i) * (XW+MW)'(Recip);
  assign q1_d     = QW'(est_prod >> XW);

  assign chk_prod = (QW+DW)'(q1_q) * (QW+DW)'(DivW);
  assign rem_full = x1_q - XW'(chk_prod);
  assign fix      = rem_full >= XW'(Divisor);
  assign q2_d     = q1_q + QW'(fix);
  assign r2_d     = DW'(fix ? rem_full - XW'(Divisor) : rem_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x_i;
    q1_q <= q1_d;
    s1_q <= side_i;
    q2_q <= q2_d;
    r2_q <= r2_d;
    s2_q <= s1_q;
  end

  assign valid_o = v2_q;
  assign q_o     = q2_q;
  assign r_o     = r2_q;
  assign side_o  = s2_q;

  a_valid_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##2 valid_o)
    else $error("item lost in divider");
  a_valid_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, 2))
    else $error("divider produced an item from nothing");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> r_o < DivW)
    else $error("divider remainder not below divisor");

endmodule

FILE: design/unix_seconds_to_civil_datetime_unit.sv
// top level: signed unix seconds to proleptic gregorian date and time of day
// depends on ucd_pkg and ucd_const_div
//
// A new item is taken in every cycle: busy_o stays low and the pipeline never
// stalls. Each item leaves flagged by done_o for a single cycle, in the order
// of acceptance. The stages are, in order: the offset add and range check, the
// divisions by constants for seconds per day in two halves, the two by 60 and
// the century, the year-step product, the division for the day of year, the
// year and month assembly, the division for the day of month, and the output
// register; seven divisions by constants in all. Items outside the supported
// span come out with out_of_range_o set and all other fields 0.
module unix_seconds_to_civil_datetime_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [47:0] unix_seconds_i,
  output logic               done_o,
  output logic signed [21:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_of_month_o,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o,
  output logic               out_of_range_o
);

  import ucd_pkg::*;

  localparam int unsigned Latency = 18;

  // offset add and range check
  logic [48:0] shifted;
  logic        a_v_q, a_oor_q;
  logic [46:0] a_total_q;

  assign shifted = {unix_seconds_i[47], unix_seconds_i} + ShiftSecs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_oor_q   <= shifted[48] | (shifted[47:0] > MaxShifted);
    a_total_q <= shifted[46:0];
  end

  // seconds to days, high half
  logic        d1_v;
  logic [10:0] d1_q;
  logic [9:0]  d1_r;
  logic [27:0] d1_s;

  ucd_const_div #(.Divisor(DayRest), .XW(20), .QW(11), .SW(28)) u_div_day_hi (
    .clk_i, .rst_ni,
    .valid_i (a_v_q),
    .x_i     (a_total_q[46:27]),
    .side_i  ({a_oor_q, a_total_q[26:0]}),
    .valid_o (d1_v),
    .q_o     (d1_q),
    .r_o     (d1_r),
    .side_o  (d1_s)
  );

  // seconds to days, low half
  logic        d2_v;
  logic [19:0] d2_q;
  logic [9:0]  d2_r;
  logic [18:0] d2_s;
  logic [29:0] days;
  logic [16:0] sod;

  ucd_const_div #(.Divisor(DayRest), .XW(30), .QW(20), .SW(19)) u_div_day_lo (
    .clk_i, .rst_ni,
    .valid_i (d1_v),
    .x_i     ({d1_r, d1_s[26:7]}),
    .side_i  ({d1_s[27], d1_q, d1_s[6:0]}),
    .valid_o (d2_v),
    .q_o     (d2_q),
    .r_o     (d2_r),
    .side_o  (d2_s)
  );

  assign days = 30'({d2_s[17:7], d2_q});
  assign sod  = {d2_r, d2_s[6:0]};

  // seconds of day to minutes and seconds
  logic        d3_v;
  logic [10:0] d3_q;
  logic [5:0]  d3_r;
  logic [30:0] d3_s;

  ucd_const_div #(.Divisor(MinSecs), .XW(17), .QW(11), .SW(31)) u_div_min (
    .clk_i, .rst_ni,
    .valid_i (d2_v),
    .x_i     (sod),
    .side_i  ({d2_s[18], days}),
    .valid_o (d3_v),
    .q_o     (d3_q),
    .r_o     (d3_r),
    .side_o  (d3_s)
  );

  // minutes to hours and minutes
  logic        d4_v;
  logic [4:0]  d4_q;
  logic [5:0]  d4_r;
  logic [36:0] d4_s;

  ucd_const_div #(.Divisor(MinSecs), .XW(11), .QW(5), .SW(37)) u_div_hour (
    .clk_i, .rst_ni,
    .valid_i (d3_v),
    .x_i     (d3_q),
    .side_i  ({d3_s, d3_r}),
    .valid_o (d4_v),
    .q_o     (d4_q),
    .r_o     (d4_r),
    .side_o  (d4_s)
  );

  // century and day of century
  logic        d5_v;
  logic [14:0] d5_q;
  logic [17:0] d5_r;
  logic [17:0] d5_s;

  ucd_const_div #(.Divisor(EraDays), .XW(32), .QW(15), .SW(18)) u_div_cent (
    .clk_i, .rst_ni,
    .valid_i (d4_v),
    .x_i     ({d4_s[35:6], 2'b11}),
    .side_i  ({d4_s[36], d4_q, d4_r, d4_s[5:0]}),
    .valid_o (d5_v),
    .q_o     (d5_q),
    .r_o     (d5_r),
    .side_o  (d5_s)
  );

  // year step product
  logic        p_v_q;
  logic [38:0] p_q;
  logic [14:0] p_cent_q;
  logic [17:0] p_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= d5_v;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= 39'({d5_r[17:2], 2'b11}) * 39'(YearStep);
    p_cent_q <= d5_q;
    p_side_q <= d5_s;
  end

  // day of year
  logic        d6_v;
  logic [8:0]  d6_q;
  logic [39:0] d6_s;

  ucd_const_div #(.Divisor(YearStepQuad), .XW(32), .QW(9), .SW(40)) u_div_doy (
    .clk_i, .rst_ni,
    .valid_i (p_v_q),
    .x_i     (p_q[31:0]),
    .side_i  ({p_side_q, p_cent_q, p_q[38:32]}),
    .valid_o (d6_v),
    .q_o     (d6_q),
    .r_o     (),
    .side_o  (d6_s)
  );

  // year and month assembly
  logic        jan;
  logic [19:0] n4;
  logic [21:0] year_d;
  logic [3:0]  mon_d;
  logic        y_v_q;
  logic [21:0] y_year_q;
  logic [3:0]  y_mon_q;
  logic [15:0] y_frac_q;
  logic [17:0] y_side_q;

  assign jan    = d6_q >= 9'(MarchYearDays);
  assign year_d = 22'(d6_s[21:7]) * 22'(CenturyYears) + 22'(d6_s[6:0]) + 22'(jan)
                  - ShiftYears;
  assign n4     = 20'(d6_q) * 20'(MonthMul) + 20'(MonthAdd);
  assign mon_d  = jan ? n4[19:16] - 4'(MonthsPerYear) : n4[19:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_v_q <= 1'b0;
    end else begin
      y_v_q <= d6_v;
    end
  end

  always_ff @(posedge clk_i) begin
    y_year_q <= year_d;
    y_mon_q  <= mon_d;
    y_frac_q <= n4[15:0];
    y_side_q <= d6_s[39:22];
  end

  // day of month
  logic        d7_v;
  logic [4:0]  d7_q;
  logic [43:0] d7_s;

  ucd_const_div #(.Divisor(MonthMul), .XW(16), .QW(5), .SW(44)) u_div_dom (
    .clk_i, .rst_ni,
    .valid_i (y_v_q),
    .x_i     (y_frac_q),
    .side_i  ({y_side_q, y_year_q, y_mon_q}),
    .valid_o (d7_v),
    .q_o     (d7_q),
    .r_o     (),
    .side_o  (d7_s)
  );

  // output register
  logic        o_v_q, o_oor_q;
  logic [21:0] o_year_q;
  logic [3:0]  o_mon_q;
  logic [4:0]  o_day_q, o_hour_q;
  logic [5:0]  o_min_q, o_sec_q;
  logic        oor;

  assign oor = d7_s[43];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= d7_v;
    end
  end

  always_ff @(posedge clk_i) begin
    o_oor_q <= oor;
    if (oor) begin
      o_year_q <= '0;
      o_mon_q  <= '0;
      o_day_q  <= '0;
      o_hour_q <= '0;
      o_min_q  <= '0;
      o_sec_q  <= '0;
    end else begin
      o_year_q <= d7_s[25:4];
      o_mon_q  <= d7_s[3:0];
      o_day_q  <= d7_q + 5'd1;
      o_hour_q <= d7_s[42:38];
      o_min_q  <= d7_s[37:32];
      o_sec_q  <= d7_s[31:26];
    end
  end

  assign busy_o         = 1'b0;
  assign done_o         = o_v_q;
  assign year_o         = o_year_q;
  assign month_o        = o_mon_q;
  assign day_of_month_o = o_day_q;
  assign hour_o         = o_hour_q;
  assign minute_o       = o_min_q;
  assign second_o       = o_sec_q;
  assign out_of_range_o = o_oor_q;

  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result without a matching item");
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> year_o == '0 && month_o == '0 &&
      day_of_month_o == '0 && hour_o == '0 && minute_o == '0 && second_o == '0)
    else $error("out of range result has nonzero fields");
  a_date_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_of_range_o |-> month_o >= 4'd1 && month_o <= 4'd12 &&
      day_of_month_o >= 5'd1 && hour_o <= 5'd23 && minute_o <= 6'd59)
    else $error("date or time field out of bounds");

endmodule

FILE: verif/civil_datetime_checker.sv
// checker for unix_seconds_to_civil_datetime_unit: predicts the civil date and time
// of every accepted item and compares it with the results in order
// no dependencies; instantiated by tb_unix_seconds_to_civil_datetime_unit
module civil_datetime_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [47:0] unix_seconds_i,
  input  logic               done_i,
  input  logic signed [21:0] year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_of_month_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic               out_of_range_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 out_of_range_seen_o
);

  localparam longint unsigned RecipSixty    = 71582789;
  localparam longint unsigned EraDays       = 146097;
  localparam longint unsigned YearStep      = 2939745;
  localparam longint unsigned MonthMul      = 2141;
  localparam longint unsigned MonthAdd      = 197913;
  localparam longint unsigned MarchYearDays = 306;
  localparam longint unsigned DaySecs       = 86400;
  localparam longint unsigned ShiftYears    = 3670 * 400;
  localparam longint ShiftSecs  = (longint'(3670) * 146097 + 719468) * 86400;
  localparam longint MaxShifted = (longint'(1) << 30) * 86400 - 1;

  typedef struct {
    logic signed [47:0] secs;
    logic signed [21:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               out_of_range;
  } civil_t;

  civil_t civil_q[$];
  civil_t want;

  function automatic civil_t civil_of_seconds(logic signed [47:0] secs);
    civil_t r;
    longint shifted;
    longint unsigned total, p1, mins, p2, prod;
    int unsigned days, sod, n1, cent, day_of_cent, doy, yshift, n4, mon, dom, yr;
    bit jan;
    r.secs = secs;
    r.year = '0;
    r.month = '0;
    r.day_of_month = '0;
    r.hour = '0;
    r.minute = '0;
    r.second = '0;
    r.out_of_range = 1'b0;
    shifted = longint'(secs) + ShiftSecs;
    if (shifted < 0 || shifted > MaxShifted) begin
      r.out_of_range = 1'b1;
      return r;
    end
    total = longint'(shifted);
    days = int'(total / DaySecs);
    sod = int'(total % DaySecs);
    // time of day through the reciprocal of sixty
    p1 = RecipSixty * longint'(sod);
    mins = p1 >> 32;
    r.second = 6'(longint'(p1[31:0]) / RecipSixty);
    p2 = RecipSixty * mins;
    r.hour = 5'(p2 >> 32);
    r.minute = 6'(longint'(p2[31:0]) / RecipSixty);
    // century, year of century, day of a march-based year
    n1 = 4 * days + 3;
    cent = int'(n1 / EraDays);
    day_of_cent = int'(n1 % EraDays);
    prod = YearStep * longint'(day_of_cent | 3);
    doy = int'(longint'(prod[31:0]) / YearStep / 4);
    jan = (doy >= MarchYearDays);
    yshift = 100 * cent + int'(prod >> 32) + jan;
    n4 = int'(MonthMul * doy + MonthAdd);
    mon = n4 >> 16;
    dom = int'((n4 & 32'hFFFF) / MonthMul) + 1;
    if (jan) begin
      mon = mon - 12;
    end
    yr = int'(yshift - ShiftYears);
    r.year = 22'(yr);
    r.month = 4'(mon);
    r.day_of_month = 5'(dom);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches_o < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches_o = mismatches_o + 1;
  endtask

  task automatic compare_field(string name, longint got, longint exp_val,
                               logic signed [47:0] secs);
    if (got != exp_val) begin
      report_mismatch($sformatf("seconds %0d %s got %0d want %0d", secs, name, got,
                                exp_val));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      civil_q.delete();
      mismatches_o = 0;
      pending_o = 0;
      checked_o = 0;
      out_of_range_seen_o = 0;
    end else begin
      if (done_i) begin
        if (civil_q.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = civil_q.pop_front();
          compare_field("out_of_range", longint'(out_of_range_i),
                        longint'(want.out_of_range), want.secs);
          compare_field("year", longint'(year_i), longint'(want.year), want.secs);
          compare_field("month", longint'(month_i), longint'(want.month), want.secs);
          compare_field("day_of_month", longint'(day_of_month_i),
                        longint'(want.day_of_month), want.secs);
          compare_field("hour", longint'(hour_i), longint'(want.hour), want.secs);
          compare_field("minute", longint'(minute_i), longint'(want.minute), want.secs);
          compare_field("second", longint'(second_i), longint'(want.second), want.secs);
          checked_o = checked_o + 1;
          if (want.out_of_range) begin
            out_of_range_seen_o = out_of_range_seen_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        civil_q.push_back(civil_of_seconds(unix_seconds_i));
      end
      pending_o = civil_q.size();
    end
  end

endmodule

FILE: verif/tb_unix_seconds_to_civil_datetime_unit.sv
// testbench top for unix_seconds_to_civil_datetime_unit: drives directed and random
// timestamps with random idle gaps and gives the verdict
// depends on the block under test and civil_datetime_checker
module tb_unix_seconds_to_civil_datetime_unit;

  localparam longint InLow      = -46387767571200;
  localparam longint InHigh     = 46383526022399;
  localparam longint InSpan     = InHigh - InLow + 1;
  localparam int     NumRandom  = 750;
  localparam int     NumDirect  = 21;
  localparam int     CycleLimit = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [47:0] unix_seconds_i;
  logic               done_o;
  logic signed [21:0] year_o;
  logic [3:0]         month_o;
  logic [4:0]         day_of_month_o;
  logic [4:0]         hour_o;
  logic [5:0]         minute_o;
  logic [5:0]         second_o;
  logic               out_of_range_o;

  int mismatches;
  int pending;
  int checked;
  int out_of_range_seen;
  int cycles;

  longint directed [NumDirect] = '{
    0, -1, 1, 86399, -86400, -86401,
    951782400, 951868800, 946684799, 946684800,
    -2208988800, -2203891200, 2147483647, -2147483648,
    InLow, InLow - 1, InHigh, InHigh + 1,
    -140737488355328, 140737488355327, -62167219200
  };

  unix_seconds_to_civil_datetime_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .unix_seconds_i (unix_seconds_i),
    .done_o         (done_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .out_of_range_o (out_of_range_o)
  );

  civil_datetime_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_i              (busy_o),
    .unix_seconds_i      (unix_seconds_i),
    .done_i              (done_o),
    .year_i              (year_o),
    .month_i             (month_o),
    .day_of_month_i      (day_of_month_o),
    .hour_i              (hour_o),
    .minute_i            (minute_o),
    .second_i            (second_o),
    .out_of_range_i      (out_of_range_o),
    .mismatches_o        (mismatches),
    .pending_o           (pending),
    .checked_o           (checked),
    .out_of_range_seen_o (out_of_range_seen)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint random_seconds();
    longint v;
    longint unsigned day;
    case ($urandom_range(0, 9))
      0: v = longint'({{16{1'b0}}, rand64()} << 16) >>> 16;
      1: begin
        v = longint'($urandom_range(0, 200000)) - 100000;
        v = v + (($urandom_range(0, 1) == 1) ? InHigh : InLow);
      end
      2: begin
        day = rand64() % (longint'(1) << 30);
        v = longint'(day) * 86400 + InLow;
        v = v + (($urandom_range(0, 1) == 1) ? 86399 : 0);
      end
      3: v = longint'(int'($urandom));
      default: v = InLow + longint'(rand64() % InSpan);
    endcase
    return v;
  endfunction

  // one item: optional idle gap, then hold start until accepted
  task automatic send_item(longint v, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    unix_seconds_i <= v[47:0];
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  initial begin
    bit idle_on;
    int gap;
    cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    unix_seconds_i = '0;
    idle_on = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NumDirect; i++) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      send_item(directed[i], gap);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 50 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
      end
      gap = 0;
      if (idle_on && i < NumRandom - 100 && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 4);
      end
      send_item(random_seconds(), gap);
    end
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("checked %0d results, %0d of them out of range", checked, out_of_range_seen);
    $display("directed range ends, calendar edges and random timestamps over 48 bits");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
